// ----- design/vvpu_pkg.sv -----
// Package: shared types and constants for the particle update unit.
`default_nettype none
package vvpu_pkg;
    localparam int REG_W = 31;
    localparam int VAL_W = 32;
    localparam int SQ_W  = 63;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_KICK  = 2'd1,
        MODE_DRIFT = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_KICK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HMASS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 3'd5;

    localparam logic [REG_W-1:0] BOX_RESET = 31'd655360;
    localparam logic [SQ_W-1:0] MAX63 = {SQ_W{1'b1}};

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } vec_t;

    typedef struct packed {
        vec_t pos;
        vec_t vel;
        vec_t disp;
    } part_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[VAL_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- design/velocity_verlet_particle_update_unit.sv -----
// Top level: velocity Verlet particle update over a particle memory.
// Slave channel s_axis_*: one word per particle operation. tuser holds mode,
// tlast marks the last particle of a kick pass, tdata holds index and vectors.
// Master channel m_axis_*: one result word for every input word.
// Configuration: cfg_we/cfg_idx/cfg_data write kick_factor, drift_step,
// half_mass and the three box lengths; write only while the block is idle.
// Each word runs through a sequencer after it is accepted: memory read,
// force or velocity products, accumulate and wrap, squares, then square
// latch, sum update and energy products, and last writeback. The result
// word is registered at writeback. One multiplier group per axis is shared
// among the steps and tready is high only in idle, so a new word is taken
// only once the earlier word has left the sequencer; the memory read-modify-write
// and the energy multiply are the reason for this.
// The result sits in an output register; the next word is taken while it
// waits, and the sequencer holds in its last step while the register is full.
// Reset clears control state and the energy sum; particle memory contents
// are undefined until loaded. No clearing pass is made.
`default_nettype none
module velocity_verlet_particle_update_unit
    import vvpu_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: particle[9:0], first_x, first_y, first_z, second_x, second_y, second_z, pad
    input  wire logic [207:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: out_x, out_y, out_z, square[62:0], energy[62:0], wrap_fault, pad
    output logic [223:0]      m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [REG_W-1:0]     cfg_data
);
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_SQ    = 7'b0010000,
        ST_EN    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [REG_W-1:0] kick_reg, drift_reg, hmass_reg, box_x_reg, box_y_reg, box_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_reg  <= '0;
            drift_reg <= '0;
            hmass_reg <= '0;
            box_x_reg <= BOX_RESET;
            box_y_reg <= BOX_RESET;
            box_z_reg <= BOX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_KICK:  kick_reg  <= cfg_data;
                CFG_DRIFT: drift_reg <= cfg_data;
                CFG_HMASS: hmass_reg <= cfg_data;
                CFG_BOX_X: box_x_reg <= cfg_data;
                CFG_BOX_Y: box_y_reg <= cfg_data;
                CFG_BOX_Z: box_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // particle memory
    part_t mem [MAX_PARTICLES];
    part_t rd_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    part_t         wr_data;

    // item registers
    mode_t      mode_reg;
    logic [9:0] idx_reg;
    logic       last_reg;
    vec_t       a_reg, b_reg;
    logic       ok_reg;

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_t'(s_axis_tuser);
            idx_reg  <= s_axis_tdata[9:0];
            last_reg <= s_axis_tlast;
            a_reg.x  <= s_axis_tdata[41:10];
            a_reg.y  <= s_axis_tdata[73:42];
            a_reg.z  <= s_axis_tdata[105:74];
            b_reg.x  <= s_axis_tdata[137:106];
            b_reg.y  <= s_axis_tdata[169:138];
            b_reg.z  <= s_axis_tdata[201:170];
            ok_reg   <= ({6'd0, s_axis_tdata[9:0]} < 16'(MAX_PARTICLES)) ||
                        (MAX_PARTICLES > 1024);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            rd_reg <= mem[AW'(idx_reg)];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    part_t cur;
    assign cur = ok_reg ? rd_reg : part_t'('0);

    // shared multipliers: 33x33 signed per axis
    logic signed [32:0] ma [3];
    logic signed [32:0] mb [3];
    logic signed [65:0] prod_reg [3];
    logic signed [31:0] cur_v [3];
    logic signed [31:0] cur_p [3];
    logic signed [31:0] cur_d [3];
    logic signed [31:0] frc [3];
    logic [REG_W-1:0]   boxv [3];
    assign cur_v = '{cur.vel.x, cur.vel.y, cur.vel.z};
    assign cur_p = '{cur.pos.x, cur.pos.y, cur.pos.z};
    assign cur_d = '{cur.disp.x, cur.disp.y, cur.disp.z};
    assign frc   = '{a_reg.x, a_reg.y, a_reg.z};
    assign boxv  = '{box_x_reg, box_y_reg, box_z_reg};

    logic signed [31:0] nv_reg [3];
    logic signed [31:0] np_reg [3];
    logic signed [31:0] nd_reg [3];
    logic [2:0]         fault_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        sum_next;
    logic [63:0]        ea_reg, eb_reg;
    logic [SQ_W-1:0]    energy_val;
    logic signed [31:0] res [3];

    // result vector for squaring
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            res[i] = (mode_reg == MODE_KICK) ? nv_reg[i] : nd_reg[i];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma[i] = '0;
            mb[i] = '0;
            if (state_reg == ST_MUL)
            begin
                if (mode_reg == MODE_KICK)
                begin
                    ma[i] = {2'b00, kick_reg};
                    mb[i] = {frc[i][31], frc[i]};
                end
                else
                begin
                    ma[i] = {2'b00, drift_reg};
                    mb[i] = {cur_v[i][31], cur_v[i]};
                end
            end
            else if (state_reg == ST_SQ)
            begin
                ma[i] = {res[i][31], res[i]};
                mb[i] = {res[i][31], res[i]};
            end
            else if (state_reg == ST_EN && i < 2)
            begin
                ma[i] = {2'b00, hmass_reg};
                mb[i] = (i == 0) ? {1'b0, sum_reg[31:0]} : {1'b0, sum_reg[63:32]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= ma[i] * mb[i];
    end

    // accumulate, wrap
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [31:0] st;
                logic signed [34:0] q;
                logic signed [34:0] l;
                st = sat32(prod_reg[i] >>> 16);
                l  = {4'd0, boxv[i]};
                unique case (mode_reg)
                    MODE_LOAD:
                    begin
                        np_reg[i] <= (i == 0) ? a_reg.x : (i == 1) ? a_reg.y : a_reg.z;
                        nv_reg[i] <= (i == 0) ? b_reg.x : (i == 1) ? b_reg.y : b_reg.z;
                        nd_reg[i] <= '0;
                        fault_reg[i] <= 1'b0;
                    end
                    MODE_KICK:
                    begin
                        np_reg[i] <= cur_p[i];
                        nv_reg[i] <= sat32(66'(cur_v[i]) + (prod_reg[i] >>> 16));
                        nd_reg[i] <= cur_d[i];
                        fault_reg[i] <= 1'b0;
                    end
                    MODE_DRIFT:
                    begin
                        q = 35'(cur_p[i]) + 35'(st);
                        if (q < 0)
                            q = q + l;
                        else if (q >= l)
                            q = q - l;
                        fault_reg[i] <= (q < 0) || (q >= l);
                        np_reg[i] <= sat32(66'(q));
                        nv_reg[i] <= cur_v[i];
                        nd_reg[i] <= sat32(66'(cur_d[i]) + 66'(st));
                    end
                    MODE_READ:
                    begin
                        np_reg[i] <= cur_p[i];
                        nv_reg[i] <= cur_v[i];
                        nd_reg[i] <= cur_d[i];
                        fault_reg[i] <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // square sum (ST_EN sees products of ST_SQ)
    logic [65:0] sqs;
    assign sqs = 66'(prod_reg[0]) + 66'(prod_reg[1]) + 66'(prod_reg[2]);

    always_comb
    begin
        logic [64:0] s;
        sum_next = sum_reg;
        s = {1'b0, sum_reg} + {1'b0, sq_reg};
        if (mode_reg == MODE_KICK)
            sum_next = s[64] ? '1 : s[63:0];
    end

    logic [1:0] en_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (state_reg == ST_EN && en_cnt_reg == 2'd1)
            sum_reg <= sum_next;
        else if (state_reg == ST_DONE && mode_reg == MODE_KICK && last_reg)
            sum_reg <= '0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EN && en_cnt_reg == 2'd0)
            sq_reg <= (sqs[65:63] != 3'd0) ? {1'b0, MAX63} : sqs[63:0];
        if (state_reg == ST_EN && en_cnt_reg == 2'd3)
        begin
            ea_reg <= prod_reg[0][63:0];
            eb_reg <= prod_reg[1][63:0];
        end
    end

    always_comb
    begin
        logic [64:0] t;
        t = {1'b0, eb_reg[47:0], 16'd0} + {17'd0, ea_reg[63:16]};
        if (eb_reg > 64'(MAX63 >> 16))
            energy_val = MAX63;
        else if (t[64:63] != 2'd0)
            energy_val = MAX63;
        else
            energy_val = t[62:0];
    end

    // sequencer
    logic out_full_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            en_cnt_reg <= '0;
        else if (state_reg == ST_EN)
            en_cnt_reg <= en_cnt_reg + 2'd1;
        else if (state_reg == ST_DONE && !out_full_reg)
            en_cnt_reg <= '0;
        else if (state_reg != ST_DONE)
            en_cnt_reg <= '0;
    end

    // en_cnt: 0 latch square, 1 sum update, 2 energy multiply, 3 energy product latch
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_SQ;
            ST_SQ:   state_next = ST_EN;
            ST_EN:   if (en_cnt_reg == 2'd3) state_next = ST_DONE;
            ST_DONE: if (!out_full_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ST_EN drives energy operands on all counts; product valid at count 3
    logic done_fire;
    assign done_fire = (state_reg == ST_DONE) && !out_full_reg;

    assign wr_en   = done_fire && ok_reg && (mode_reg != MODE_READ);
    assign wr_addr = AW'(idx_reg);
    assign wr_data = '{pos:  '{np_reg[0], np_reg[1], np_reg[2]},
                       vel:  '{nv_reg[0], nv_reg[1], nv_reg[2]},
                       disp: '{nd_reg[0], nd_reg[1], nd_reg[2]}};

    logic [223:0] out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (done_fire)
            out_full_reg <= 1'b1;
        else if (m_axis_tready)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            logic [SQ_W-1:0] sqo;
            logic [SQ_W-1:0] eno;
            sqo = (mode_reg == MODE_LOAD) ? '0 : sq_reg[SQ_W-1:0];
            eno = (mode_reg == MODE_KICK && last_reg) ? energy_val : '0;
            if (mode_reg == MODE_KICK)
                out_data_reg <= {1'b0, (mode_reg == MODE_DRIFT) && (|fault_reg),
                                 eno, sqo, nv_reg[2], nv_reg[1], nv_reg[0]};
            else
                out_data_reg <= {1'b0, (mode_reg == MODE_DRIFT) && (|fault_reg),
                                 eno, sqo, np_reg[2], np_reg[1], np_reg[0]};
        end
    end

    assign m_axis_tvalid = out_full_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule
`default_nettype wire

// ----- design/vvpu_checker.sv -----
// Checker: port-level properties of the particle update unit, with its bind.
`default_nettype none
module vvpu_checker
    import vvpu_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [223:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a word while busy");
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too early");
    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[222] |-> m_axis_tdata[221:159] == '0)
        else $error("wrap fault with energy set");
endmodule

bind velocity_verlet_particle_update_unit vvpu_checker u_vvpu_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
